// File: src/hic_pkg.sv
// ----------------------------------------------------------------------------
// hic_pkg
// Shared types and constants for the homography inlier counter.
// ----------------------------------------------------------------------------
package hic_pkg;

   localparam int COEF_W  = 32;
   localparam int PIX_W   = 12;
   localparam int CNT_W   = 11;
   localparam int NCOEF   = 8;
   localparam int CSR_AW  = 3;
   localparam int PROD_W  = 44;              // 32b signed x 12b unsigned
   localparam int PROJ_W  = 47;              // sum of two products and a term
   localparam int FRAC_W  = 16;
   localparam int NUM_W   = PROJ_W + FRAC_W; // |X| << 16
   localparam int REM_W   = PROJ_W + 1;
   localparam int STEP_W  = 6;
   localparam int DIFF_W  = NUM_W + 2;
   localparam int MAG_W   = 26;
   localparam int SQ_W    = 2 * MAG_W;

   localparam int MAX_POINTS   = 1024;
   localparam int INLIER_LIMIT = 4;
   localparam int CNT_FIELD_MAX = (1 << CNT_W) - 1;
   localparam int CNT_CAP_I = (MAX_POINTS < CNT_FIELD_MAX) ? MAX_POINTS : CNT_FIELD_MAX;
   localparam logic [CNT_W-1:0]  CNT_CAP   = CNT_W'(CNT_CAP_I);
   localparam logic [SQ_W:0]     LIMIT_SQ  = (SQ_W+1)'(64'(INLIER_LIMIT) << 32);
   localparam logic [DIFF_W-1:0] ERR_BOUND = DIFF_W'(1) << 25;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

   localparam logic signed [COEF_W-1:0] ONE_Q16 = COEF_W'(65536);

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_COEF_A = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_COEF_B = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_COEF_C = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_COEF_D = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_COEF_E = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_COEF_F = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_COEF_G = 3'd6;
   localparam logic [CSR_AW-1:0] CSR_COEF_H = 3'd7;

   typedef struct packed {
      logic signed [PROJ_W-1:0] px;
      logic signed [PROJ_W-1:0] py;
      logic signed [PROJ_W-1:0] pz;
      logic [PIX_W-1:0]         u;
      logic [PIX_W-1:0]         v;
      logic                     last;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_ERR,
      BK_SQ,
      BK_DONE
   } back_state_type;

endpackage

// File: src/hic_front.sv
// ----------------------------------------------------------------------------
// hic_front
// Holds the matrix, takes words and forms the projected X, Y and Z.
// ----------------------------------------------------------------------------
module hic_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [hic_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [hic_pkg::COEF_W-1:0]   csr_wdata,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [hic_pkg::PIX_W-1:0]    in_x,
   input  logic [hic_pkg::PIX_W-1:0]    in_y,
   input  logic [hic_pkg::PIX_W-1:0]    in_u,
   input  logic [hic_pkg::PIX_W-1:0]    in_v,
   input  logic                         in_last,
   output logic                         out_valid,
   input  logic                         out_ready,
   output hic_pkg::item_type            out_item
);

   logic signed [hic_pkg::COEF_W-1:0] coef_ff [hic_pkg::NCOEF];

   logic                         s1_valid_ff, s1_valid_in;
   logic [hic_pkg::PIX_W-1:0]    x_ff, y_ff, u1_ff, v1_ff;
   logic                         last1_ff;

   logic                         s2_valid_ff, s2_valid_in;
   logic signed [hic_pkg::PROD_W-1:0] prod_ff [6];
   logic signed [hic_pkg::PROD_W-1:0] prod_in [6];
   logic signed [hic_pkg::COEF_W-1:0] c_ff, f_ff;
   logic [hic_pkg::PIX_W-1:0]    u2_ff, v2_ff;
   logic                         last2_ff;

   logic                         s2_adv;
   logic signed [hic_pkg::PROD_W-1:0] xs, ys;

   always_ff @(posedge clock) begin
      if (reset) begin
         // identity matrix
         for (int i = 0; i < hic_pkg::NCOEF; i++) begin
            coef_ff[i] <= (i == hic_pkg::CSR_COEF_A || i == hic_pkg::CSR_COEF_E)
                          ? hic_pkg::ONE_Q16 : '0;
         end
      end else if (csr_we) begin
         coef_ff[csr_addr] <= csr_wdata;
      end
   end

   assign s2_adv      = !s2_valid_ff || out_ready;
   assign in_ready    = !s1_valid_ff || s2_adv;
   assign s1_valid_in = in_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;

   assign xs = hic_pkg::PROD_W'($signed({1'b0, x_ff}));
   assign ys = hic_pkg::PROD_W'($signed({1'b0, y_ff}));

   always_comb begin
      prod_in[0] = hic_pkg::PROD_W'(coef_ff[hic_pkg::CSR_COEF_A]) * xs;
      prod_in[1] = hic_pkg::PROD_W'(coef_ff[hic_pkg::CSR_COEF_B]) * ys;
      prod_in[2] = hic_pkg::PROD_W'(coef_ff[hic_pkg::CSR_COEF_D]) * xs;
      prod_in[3] = hic_pkg::PROD_W'(coef_ff[hic_pkg::CSR_COEF_E]) * ys;
      prod_in[4] = hic_pkg::PROD_W'(coef_ff[hic_pkg::CSR_COEF_G]) * xs;
      prod_in[5] = hic_pkg::PROD_W'(coef_ff[hic_pkg::CSR_COEF_H]) * ys;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         x_ff     <= in_x;
         y_ff     <= in_y;
         u1_ff    <= in_u;
         v1_ff    <= in_v;
         last1_ff <= in_last;
      end
      if (s2_adv) begin
         for (int i = 0; i < 6; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         c_ff     <= coef_ff[hic_pkg::CSR_COEF_C];
         f_ff     <= coef_ff[hic_pkg::CSR_COEF_F];
         u2_ff    <= u1_ff;
         v2_ff    <= v1_ff;
         last2_ff <= last1_ff;
      end
   end

   assign out_valid     = s2_valid_ff;
   assign out_item.px   = hic_pkg::PROJ_W'(prod_ff[0]) + hic_pkg::PROJ_W'(prod_ff[1])
                        + hic_pkg::PROJ_W'(c_ff);
   assign out_item.py   = hic_pkg::PROJ_W'(prod_ff[2]) + hic_pkg::PROJ_W'(prod_ff[3])
                        + hic_pkg::PROJ_W'(f_ff);
   assign out_item.pz   = hic_pkg::PROJ_W'(prod_ff[4]) + hic_pkg::PROJ_W'(prod_ff[5])
                        + hic_pkg::PROJ_W'(hic_pkg::ONE_Q16);
   assign out_item.u    = u2_ff;
   assign out_item.v    = v2_ff;
   assign out_item.last = last2_ff;

endmodule

// File: src/hic_queue.sv
// ----------------------------------------------------------------------------
// hic_queue
// Two-entry queue of projected points between front and back.
// ----------------------------------------------------------------------------
module hic_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  hic_pkg::item_type  in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output hic_pkg::item_type  out_item
);

   hic_pkg::item_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem[rd_ptr_ff];

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   assign fill_in   = fill_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: src/hic_back.sv
// ----------------------------------------------------------------------------
// hic_back
// Divides by Z one bit a cycle, checks the error and keeps the count.
// ----------------------------------------------------------------------------
module hic_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  hic_pkg::item_type           in_item,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [hic_pkg::CNT_W-1:0]   out_total
);

   hic_pkg::back_state_type state_ff, state_in;

   logic [hic_pkg::PROJ_W-1:0] den_ff, den_in;
   logic [hic_pkg::NUM_W-1:0]  numx_ff, numx_in, numy_ff, numy_in;
   logic [hic_pkg::NUM_W-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic [hic_pkg::REM_W-1:0]  remx_ff, remx_in, remy_ff, remy_in;
   logic                       negx_ff, negx_in, negy_ff, negy_in;
   logic [hic_pkg::STEP_W-1:0] step_ff, step_in;
   logic [hic_pkg::PIX_W-1:0]  u_ff, u_in, v_ff, v_in;
   logic                       last_ff, last_in;
   logic                       okx_ff, okx_in, oky_ff, oky_in;
   logic [hic_pkg::MAG_W-1:0]  mx_ff, mx_in, my_ff, my_in;
   logic [hic_pkg::SQ_W-1:0]   sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [hic_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [hic_pkg::CNT_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                       zero_den, done_go, inlier;
   logic [hic_pkg::CNT_W-1:0]  count_next;
   logic [hic_pkg::REM_W-1:0]  trialx, trialy;
   logic signed [hic_pkg::DIFF_W-1:0] dx, dy;
   logic [hic_pkg::DIFF_W-1:0] ax, ay;
   logic [hic_pkg::SQ_W:0]     sq_sum;

   assign zero_den = (in_item.pz == '0);
   assign in_ready = (state_ff == hic_pkg::BK_IDLE);
   assign done_go  = !last_ff || !rsp_valid_ff || out_ready;

   // restoring division step, remainder stays below the divisor
   assign trialx = {remx_ff[hic_pkg::REM_W-2:0], numx_ff[hic_pkg::NUM_W-1]};
   assign trialy = {remy_ff[hic_pkg::REM_W-2:0], numy_ff[hic_pkg::NUM_W-1]};

   assign dx = (negx_ff ? -$signed({2'b00, qx_ff}) : $signed({2'b00, qx_ff}))
             - $signed(hic_pkg::DIFF_W'({u_ff, 16'h0000}));
   assign dy = (negy_ff ? -$signed({2'b00, qy_ff}) : $signed({2'b00, qy_ff}))
             - $signed(hic_pkg::DIFF_W'({v_ff, 16'h0000}));
   assign ax = dx[hic_pkg::DIFF_W-1] ? hic_pkg::DIFF_W'(-dx) : hic_pkg::DIFF_W'(dx);
   assign ay = dy[hic_pkg::DIFF_W-1] ? hic_pkg::DIFF_W'(-dy) : hic_pkg::DIFF_W'(dy);

   assign sq_sum     = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign inlier     = okx_ff && oky_ff && (sq_sum <= hic_pkg::LIMIT_SQ);
   assign count_next = (inlier && count_ff < hic_pkg::CNT_CAP) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hic_pkg::BK_IDLE: begin
            if (in_valid) begin
               state_in = zero_den ? hic_pkg::BK_DONE : hic_pkg::BK_DIV;
            end
         end
         hic_pkg::BK_DIV: begin
            if (step_ff == hic_pkg::LAST_STEP) begin
               state_in = hic_pkg::BK_ERR;
            end
         end
         hic_pkg::BK_ERR:  state_in = hic_pkg::BK_SQ;
         hic_pkg::BK_SQ:   state_in = hic_pkg::BK_DONE;
         hic_pkg::BK_DONE: begin
            if (done_go) begin
               state_in = hic_pkg::BK_IDLE;
            end
         end
         default: state_in = hic_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      den_in       = den_ff;
      numx_in      = numx_ff;
      numy_in      = numy_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      remx_in      = remx_ff;
      remy_in      = remy_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      step_in      = step_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      last_in      = last_ff;
      okx_in       = okx_ff;
      oky_in       = oky_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         hic_pkg::BK_IDLE: begin
            den_in  = in_item.pz[hic_pkg::PROJ_W-1] ? hic_pkg::PROJ_W'(-in_item.pz)
                                                    : hic_pkg::PROJ_W'(in_item.pz);
            numx_in = {(in_item.px[hic_pkg::PROJ_W-1] ? hic_pkg::PROJ_W'(-in_item.px)
                                                      : hic_pkg::PROJ_W'(in_item.px)),
                       16'h0000};
            numy_in = {(in_item.py[hic_pkg::PROJ_W-1] ? hic_pkg::PROJ_W'(-in_item.py)
                                                      : hic_pkg::PROJ_W'(in_item.py)),
                       16'h0000};
            negx_in = in_item.px[hic_pkg::PROJ_W-1] ^ in_item.pz[hic_pkg::PROJ_W-1];
            negy_in = in_item.py[hic_pkg::PROJ_W-1] ^ in_item.pz[hic_pkg::PROJ_W-1];
            remx_in = '0;
            remy_in = '0;
            qx_in   = '0;
            qy_in   = '0;
            step_in = '0;
            u_in    = in_item.u;
            v_in    = in_item.v;
            last_in = in_item.last;
            okx_in  = 1'b0;
            oky_in  = 1'b0;
         end
         hic_pkg::BK_DIV: begin
            if (trialx >= {1'b0, den_ff}) begin
               remx_in = trialx - {1'b0, den_ff};
               qx_in   = {qx_ff[hic_pkg::NUM_W-2:0], 1'b1};
            end else begin
               remx_in = trialx;
               qx_in   = {qx_ff[hic_pkg::NUM_W-2:0], 1'b0};
            end
            if (trialy >= {1'b0, den_ff}) begin
               remy_in = trialy - {1'b0, den_ff};
               qy_in   = {qy_ff[hic_pkg::NUM_W-2:0], 1'b1};
            end else begin
               remy_in = trialy;
               qy_in   = {qy_ff[hic_pkg::NUM_W-2:0], 1'b0};
            end
            numx_in = numx_ff << 1;
            numy_in = numy_ff << 1;
            step_in = step_ff + 1'b1;
         end
         hic_pkg::BK_ERR: begin
            okx_in = (ax <= hic_pkg::ERR_BOUND);
            oky_in = (ay <= hic_pkg::ERR_BOUND);
            mx_in  = ax[hic_pkg::MAG_W-1:0];
            my_in  = ay[hic_pkg::MAG_W-1:0];
         end
         hic_pkg::BK_SQ: begin
            sqx_in = mx_ff * mx_ff;
            sqy_in = my_ff * my_ff;
         end
         hic_pkg::BK_DONE: begin
            if (done_go) begin
               count_in = count_next;
               if (last_ff) begin
                  count_in     = '0;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = count_next;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hic_pkg::BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff      <= den_in;
      numx_ff     <= numx_in;
      numy_ff     <= numy_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      remx_ff     <= remx_in;
      remy_ff     <= remy_in;
      negx_ff     <= negx_in;
      negy_ff     <= negy_in;
      step_ff     <= step_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      last_ff     <= last_in;
      okx_ff      <= okx_in;
      oky_ff      <= oky_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_total = rsp_data_ff;

endmodule

// File: src/homography_inlier_counter.sv
// ----------------------------------------------------------------------------
// homography_inlier_counter
// Maps points through a projective matrix and counts inliers per set.
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (low bit up)           tlast
//  req      in   src_x, src_y, dst_u, dst_v          last_point
//  rsp      out  inlier_total                        -
//  csr      in   csr_we / csr_addr / csr_wdata (coef_a..coef_h)
//
//  In the back end a point goes through a 63-step bit-serial
//  division by Z (X and Y in parallel), then error, square and count steps.
//  A point with Z of zero skips the division, error and square steps.
//  The front end and a 2-entry queue take words during a division until full.
//  Reset is synchronous; the matrix returns to identity, the count to zero.
//  A held result in the output register stalls only the next last word.
// ----------------------------------------------------------------------------
module homography_inlier_counter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [hic_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [hic_pkg::COEF_W-1:0]    csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [47:0]                   req_tdata,   // src_x, src_y, dst_u, dst_v
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata    // inlier_total
);

   hic_pkg::item_type            f_item, q_item;
   logic                         f_valid, f_ready, q_valid, q_ready;
   logic [hic_pkg::CNT_W-1:0]    total;

   hic_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_x      (req_tdata[11:0]),
      .in_y      (req_tdata[23:12]),
      .in_u      (req_tdata[35:24]),
      .in_v      (req_tdata[47:36]),
      .in_last   (req_tlast),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   hic_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   hic_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_total (total)
   );

   assign rsp_tdata = {5'b00000, total};

endmodule

// File: tb/homography_inlier_counter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homography_inlier_counter_checker
// Watches the point and count channels and the csr port, predicts each set
// count from its own model of the projection and compares in order.
// ----------------------------------------------------------------------------
module homography_inlier_counter_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count
);

   logic signed [63:0] mat [8];
   logic [10:0]        set_inliers;
   logic [10:0]        count_q [$];

   // true when one axis error fits; sq gets its square
   function automatic bit axis_err(input logic signed [63:0] num,
                                   input logic signed [63:0] den,
                                   input logic signed [63:0] tgt,
                                   output logic [63:0] sq);
      logic signed [63:0] q, d;
      logic [63:0]        m;
      q  = (num * 64'sd65536) / den;
      d  = q - tgt * 64'sd65536;
      m  = (d < 0) ? -d : d;
      sq = m * m;
      return m <= (64'd1 << 25);
   endfunction

   function automatic bit is_inlier(input logic [47:0] w);
      logic signed [63:0] x, y, u, v, px, py, pz;
      logic [63:0]        sx, sy;
      bit                 okx, oky;
      x  = w[11:0];
      y  = w[23:12];
      u  = w[35:24];
      v  = w[47:36];
      px = mat[0] * x + mat[1] * y + mat[2];
      py = mat[3] * x + mat[4] * y + mat[5];
      pz = mat[6] * x + mat[7] * y + 64'sd65536;
      if (pz == 0) return 0;
      okx = axis_err(px, pz, u, sx);
      oky = axis_err(py, pz, v, sy);
      if (!(okx && oky)) return 0;
      return (sx + sy) <= (64'(hic_pkg::INLIER_LIMIT) << 32);
   endfunction

   assign pending_count = count_q.size();

   always @(posedge clock) begin
      logic [10:0] n;
      if (reset) begin
         foreach (mat[i]) mat[i] <= (i == 0 || i == 4) ? 64'sd65536 : 64'sd0;
         set_inliers <= 0;
         fail_count <= 0;
         count_q.delete();
      end else begin
         if (csr_we)
            mat[csr_addr] <= $signed(csr_wdata);
         if (req_tvalid && req_tready) begin
            n = set_inliers;
            if (is_inlier(req_tdata) && n < hic_pkg::CNT_CAP) n = n + 1;
            if (req_tlast) begin
               count_q.push_back(n);
               set_inliers <= 0;
            end else begin
               set_inliers <= n;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (count_q.size() == 0) begin
               $display("%0t: unexpected count word, expected none, actual %0d",
                        $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_tdata !== {5'd0, count_q[0]}) begin
                  $display("%0t: inlier_total mismatch, expected %0d, actual %0d",
                           $time, count_q[0], rsp_tdata);
                  fail_count <= fail_count + 1;
               end
               void'(count_q.pop_front());
            end
         end
      end
   end
endmodule

// File: tb/homography_inlier_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homography_inlier_counter_tb
// Drives point sets through several matrices (identity, translation,
// perspective, extreme coefficients) with random stalls on both channels.
// ----------------------------------------------------------------------------
module homography_inlier_counter_tb;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [2:0]  csr_addr = 0;
   logic [31:0] csr_wdata = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = 0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   int          fail_count, pending_count;
   int          cycle_count = 0;
   bit          no_idle = 0;

   localparam int CYCLE_LIMIT = 2000000;

   always #1 clock = ~clock;

   homography_inlier_counter u_top (.*);

   homography_inlier_counter_checker u_check (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("homography_inlier_counter_tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= no_idle || ($urandom_range(99) >= 23);

   task automatic write_coef(input logic [2:0] idx, input logic [31:0] val);
      csr_we    <= 1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 0;
      @(posedge clock);
   endtask

   task automatic send_point(input logic [11:0] x, y, u, v, input bit last);
      if (!no_idle)
         while ($urandom_range(99) < 23) begin
            req_tvalid <= 0;
            @(posedge clock);
         end
      req_tvalid <= 1;
      req_tdata  <= {v, u, y, x};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // a trailing non-last point may still be in the back end
      repeat (300) @(posedge clock);
   endtask

   // near-matched random set: most destinations lie close to a translated source
   task automatic random_set(input int len, input int tx, input int ty);
      logic [11:0] x, y;
      int          u, v;
      for (int i = 0; i < len; i++) begin
         x = $urandom;
         y = $urandom;
         if ($urandom_range(9) < 7) begin
            u = x + tx + $urandom_range(4) - 2;
            v = y + ty + $urandom_range(4) - 2;
         end else begin
            u = $urandom;
            v = $urandom;
         end
         send_point(x, y, u[11:0], v[11:0], i == len - 1);
      end
   endtask

   initial begin
      int sent;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: identity matrix, field extremes
      send_point(12'd0, 12'd0, 12'd0, 12'd0, 0);
      send_point(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 0);
      send_point(12'hFFF, 12'd0, 12'd0, 12'hFFF, 0);
      send_point(12'd100, 12'd100, 12'd102, 12'd100, 0);  // squared error of 4: limit
      send_point(12'd100, 12'd100, 12'd102, 12'd101, 1);  // just over
      send_point(12'd5, 12'd5, 12'd5, 12'd5, 1);          // one-point set
      drain();

      // translation, then perspective that zeroes Z at x = 1
      write_coef(hic_pkg::CSR_COEF_C, 32'd10 << 16);
      write_coef(hic_pkg::CSR_COEF_F, -(32'd20 << 16));
      send_point(12'd50, 12'd50, 12'd60, 12'd30, 0);
      send_point(12'd0, 12'd0, 12'd10, 12'd0, 0);
      send_point(12'd0, 12'd4095, 12'd0, 12'd0, 1);       // error beyond 512 px
      drain();
      write_coef(hic_pkg::CSR_COEF_G, -32'sd65536);
      send_point(12'd1, 12'd0, 12'd0, 12'd0, 0);          // zero Z
      send_point(12'd1, 12'd7, 12'd3, 12'd3, 0);
      send_point(12'd2, 12'd2, 12'd0, 12'd0, 1);          // negative Z
      drain();

      // extreme coefficients
      write_coef(hic_pkg::CSR_COEF_A, 32'h7FFF_FFFF);
      write_coef(hic_pkg::CSR_COEF_B, 32'h8000_0000);
      write_coef(hic_pkg::CSR_COEF_D, 32'h8000_0000);
      write_coef(hic_pkg::CSR_COEF_E, 32'h7FFF_FFFF);
      write_coef(hic_pkg::CSR_COEF_G, 32'h7FFF_FFFF);
      write_coef(hic_pkg::CSR_COEF_H, 32'h8000_0000);
      send_point(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 0);
      send_point(12'hFFF, 12'd0, 12'd0, 12'd0, 0);
      send_point(12'd0, 12'hFFF, 12'd0, 12'd0, 1);
      drain();

      // random phases; directed words above count toward the total
      sent = 15;
      for (int ph = 0; sent < 850; ph++) begin
         int tx, ty;
         tx = $urandom_range(40) - 20;
         ty = $urandom_range(40) - 20;
         write_coef(hic_pkg::CSR_COEF_A, ph[0] ? 32'd65536 : $urandom);
         write_coef(hic_pkg::CSR_COEF_B, ph[0] ? 32'd0 : $urandom_range(200) - 100);
         write_coef(hic_pkg::CSR_COEF_C, tx << 16);
         write_coef(hic_pkg::CSR_COEF_D, ph[1] ? 32'd0 : $urandom);
         write_coef(hic_pkg::CSR_COEF_E, 32'd65536 + $urandom_range(20) - 10);
         write_coef(hic_pkg::CSR_COEF_F, ty << 16);
         write_coef(hic_pkg::CSR_COEF_G, ph[2] ? $urandom : $urandom_range(6) - 3);
         write_coef(hic_pkg::CSR_COEF_H, ph[2] ? $urandom : $urandom_range(6) - 3);
         no_idle = (ph == 3);
         for (int s = 0; s < 6; s++) begin
            int len;
            len = $urandom_range(30, 1);
            random_set(len, tx, ty);
            sent += len;
         end
         no_idle = 0;
         drain();
      end

      if (fail_count == 0)
         $display("homography_inlier_counter_tb OK");
      else
         $display("homography_inlier_counter_tb NOT OK");
      $finish;
   end
endmodule

// File: sim.f
src/hic_pkg.sv
src/hic_front.sv
src/hic_queue.sv
src/hic_back.sv
src/homography_inlier_counter.sv
tb/homography_inlier_counter_checker.sv
tb/homography_inlier_counter_tb.sv
